// ----- rtl/rsrd_pkg.sv -----
package rsrd_pkg;

    // Widths fixed by the packet format
    localparam int SEQ_W   = 32;
    localparam int LIMIT_W = 4;
    localparam int STAT_W  = 4;
    localparam int COUNT_W = 4;
    localparam int WIN_W   = 8;

    // Defaults handed to the top level
    localparam int DEFER_DEPTH_DEF = 8;
    localparam int TAG_WIDTH_DEF   = 16;

    // At most this many entries are ever in use, whatever the depth
    localparam int STORE_MAX = 8;

    // The acceptance window is this many times the defer limit
    localparam int WINDOW_FACTOR = 10;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

    localparam logic OP_PACKET  = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_DELIVER   = 4'd0,
        ST_BAD_CK    = 4'd1,
        ST_FIRST_NZ  = 4'd2,
        ST_OLD_DUP   = 4'd3,
        ST_DEFER_DUP = 4'd4,
        ST_FULL      = 4'd5,
        ST_DEFERRED  = 4'd6,
        ST_TOO_FAR   = 4'd7,
        ST_TO_FLUSH  = 4'd8,
        ST_TO_EMPTY  = 4'd9
    } status_t;

endpackage

// ----- rtl/redundant_seq_reorder_dedup_unit.sv -----
// A dropped packet reports straight from classification; a deferral or a store-related
// drop reports at the end of a full slot scan; a timeout scans every slot before flushing.
// Each delivery in a run costs one slot scan, which stops at a match or the last slot;
// busy holds off the next start until the item is done.
// Results are one-cycle strobes on result_valid; the receiver cannot stall them.
// Reset: expected number zero, store empty, defer limit 8; no clearing pass is needed.
module redundant_seq_reorder_dedup_unit #(
    parameter int DEFER_DEPTH = rsrd_pkg::DEFER_DEPTH_DEF,
    parameter int TAG_WIDTH   = rsrd_pkg::TAG_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // Command side
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic                          checksum_ok,
    input  logic [rsrd_pkg::SEQ_W-1:0]    seq_number,
    input  logic [TAG_WIDTH-1:0]          payload_tag,
    input  logic                          tx_started,

    // Configuration write channel (defer limit)
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rsrd_pkg::LIMIT_W-1:0]  cfg_data,

    // Result strobe
    output logic                          result_valid,
    output logic [rsrd_pkg::STAT_W-1:0]   status,
    output logic                          delivered,
    output logic [rsrd_pkg::SEQ_W-1:0]    out_seq,
    output logic [TAG_WIDTH-1:0]          out_tag,
    output logic                          last
);

    // Only the first STORE_MAX slots can ever be filled: capacity never exceeds it.
    localparam int SLOTS = (DEFER_DEPTH < rsrd_pkg::STORE_MAX) ? DEFER_DEPTH
                                                               : rsrd_pkg::STORE_MAX;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
    localparam int SEQ_W   = rsrd_pkg::SEQ_W;
    localparam int COUNT_W = rsrd_pkg::COUNT_W;
    localparam int WIN_W   = rsrd_pkg::WIN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_SEARCH,
        S_MIN,
        S_FLUSH
    } state_t;

    state_t                         state_reg, state_next;

    // Latched command
    logic                           op_reg, op_next;
    logic                           ck_reg, ck_next;
    logic                           txs_reg, txs_next;
    logic [SEQ_W-1:0]               sq_reg, sq_next;
    logic [TAG_WIDTH-1:0]           tag_reg, tag_next;

    // Architectural state
    logic [SEQ_W-1:0]               exp_reg, exp_next;
    logic [rsrd_pkg::LIMIT_W-1:0]   limit_reg, limit_next;
    logic [SLOTS-1:0]               valid_reg, valid_next;
    logic [SEQ_W-1:0]               slot_seq_reg [SLOTS];
    logic [TAG_WIDTH-1:0]           slot_tag_reg [SLOTS];

    // Scan sequencer
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic                           hit_reg, hit_next;
    logic [COUNT_W-1:0]             occ_reg, occ_next;
    logic                           free_ok_reg, free_ok_next;
    logic [IDX_W-1:0]               free_idx_reg, free_idx_next;
    logic                           best_ok_reg, best_ok_next;
    logic [SEQ_W-1:0]               best_reg, best_next;

    // Held result of a delivery run, shown once the next scan tells if it is the last
    logic                           pend_ok_reg, pend_ok_next;
    rsrd_pkg::status_t              run_code_reg, run_code_next;
    logic [SEQ_W-1:0]               pend_seq_reg, pend_seq_next;
    logic [TAG_WIDTH-1:0]           pend_tag_reg, pend_tag_next;

    // Registered outputs
    logic                           strobe_reg, strobe_next;
    rsrd_pkg::status_t              status_reg, status_next;
    logic                           dlv_reg, dlv_next;
    logic [SEQ_W-1:0]               oseq_reg, oseq_next;
    logic [TAG_WIDTH-1:0]           otag_reg, otag_next;
    logic                           last_reg, last_next;

    // Slot write port
    logic                           wr_en;
    logic [IDX_W-1:0]               wr_idx;

    // Shared compare unit
    logic [SEQ_W-1:0]               cmp_a, cmp_b;
    logic                           cmp_eq, cmp_lt;

    logic                           cur_valid;
    logic [SEQ_W-1:0]               cur_seq;
    logic [TAG_WIDTH-1:0]           cur_tag;
    logic [WIN_W-1:0]               win_span;
    logic [SEQ_W:0]                 win_top;
    logic                           in_window;
    logic [COUNT_W-1:0]             cap;
    logic [COUNT_W-1:0]             occ_final;
    logic                           hit_final;

    assign cur_valid = valid_reg[idx_reg];
    assign cur_seq   = slot_seq_reg[idx_reg];
    assign cur_tag   = slot_tag_reg[idx_reg];

    // One comparator serves classification and every slot scan
    always_comb
    begin
        case (state_reg)
            S_CLASSIFY:
            begin
                cmp_a = sq_reg;
                cmp_b = exp_reg;
            end
            S_SEARCH:
            begin
                cmp_a = cur_seq;
                cmp_b = sq_reg;
            end
            S_MIN:
            begin
                cmp_a = cur_seq;
                cmp_b = best_reg;
            end
            default:
            begin
                cmp_a = cur_seq;
                cmp_b = exp_reg;
            end
        endcase
    end

    assign cmp_eq = (cmp_a == cmp_b);
    assign cmp_lt = (cmp_a < cmp_b);

    // Window is expected + 10 * limit, taken without wrap
    assign win_span  = WIN_W'(limit_reg) * WIN_W'(rsrd_pkg::WINDOW_FACTOR);
    assign win_top   = {1'b0, exp_reg} + (SEQ_W + 1)'(win_span);
    assign in_window = ({1'b0, sq_reg} <= win_top);

    // Effective capacity: limit clipped to the slots present
    assign cap = (limit_reg < COUNT_W'(SLOTS)) ? COUNT_W'(limit_reg) : COUNT_W'(SLOTS);

    assign hit_final = hit_reg | (cur_valid & cmp_eq);
    assign occ_final = occ_reg + COUNT_W'(cur_valid);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        ck_next       = ck_reg;
        txs_next      = txs_reg;
        sq_next       = sq_reg;
        tag_next      = tag_reg;
        exp_next      = exp_reg;
        limit_next    = limit_reg;
        valid_next    = valid_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        occ_next      = occ_reg;
        free_ok_next  = free_ok_reg;
        free_idx_next = free_idx_reg;
        best_ok_next  = best_ok_reg;
        best_next     = best_reg;
        pend_ok_next  = pend_ok_reg;
        run_code_next = run_code_reg;
        pend_seq_next = pend_seq_reg;
        pend_tag_next = pend_tag_reg;
        strobe_next   = 1'b0;
        status_next   = status_reg;
        dlv_next      = 1'b0;
        oseq_next     = '0;
        otag_next     = '0;
        last_next     = 1'b0;
        wr_en         = 1'b0;
        wr_idx        = free_ok_reg ? free_idx_reg : idx_reg;

        // Take a limit write only between commands
        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = opcode;
                    ck_next    = checksum_ok;
                    txs_next   = tx_started;
                    sq_next    = seq_number;
                    tag_next   = payload_tag;
                    state_next = S_CLASSIFY;
                end
            end

            S_CLASSIFY:
            begin
                idx_next = '0;
                if (op_reg == rsrd_pkg::OP_TIMEOUT)
                begin
                    best_ok_next = 1'b0;
                    state_next   = S_MIN;
                end
                else if (!ck_reg)
                begin
                    strobe_next = 1'b1;
                    status_next = rsrd_pkg::ST_BAD_CK;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if ((exp_reg == '0) && !txs_reg && (sq_reg != '0))
                begin
                    strobe_next = 1'b1;
                    status_next = rsrd_pkg::ST_FIRST_NZ;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (cmp_lt)
                begin
                    strobe_next = 1'b1;
                    status_next = rsrd_pkg::ST_OLD_DUP;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (cmp_eq)
                begin
                    // Hold the in-order packet until the run behind it is known
                    pend_ok_next  = 1'b1;
                    run_code_next = rsrd_pkg::ST_DELIVER;
                    pend_seq_next = sq_reg;
                    pend_tag_next = tag_reg;
                    exp_next      = exp_reg + SEQ_W'(1);
                    state_next    = S_FLUSH;
                end
                else if (in_window)
                begin
                    hit_next     = 1'b0;
                    occ_next     = '0;
                    free_ok_next = 1'b0;
                    state_next   = S_SEARCH;
                end
                else
                begin
                    strobe_next = 1'b1;
                    status_next = rsrd_pkg::ST_TOO_FAR;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_SEARCH:
            begin
                // Look for a duplicate, count occupancy and note the first free slot
                hit_next = hit_final;
                occ_next = occ_final;
                if (!cur_valid && !free_ok_reg)
                begin
                    free_ok_next  = 1'b1;
                    free_idx_next = idx_reg;
                end
                if (idx_reg == IDX_LAST)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                    if (hit_final)
                    begin
                        status_next = rsrd_pkg::ST_DEFER_DUP;
                    end
                    else if (occ_final >= cap)
                    begin
                        status_next = rsrd_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en               = 1'b1;
                        valid_next[wr_idx]  = 1'b1;
                        status_next         = rsrd_pkg::ST_DEFERRED;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_MIN:
            begin
                // Find the smallest deferred number
                if (cur_valid && (!best_ok_reg || cmp_lt))
                begin
                    best_ok_next = 1'b1;
                    best_next    = cur_seq;
                end
                if (idx_reg == IDX_LAST)
                begin
                    idx_next = '0;
                    if (!best_ok_next)
                    begin
                        strobe_next = 1'b1;
                        status_next = rsrd_pkg::ST_TO_EMPTY;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        exp_next      = best_next;
                        pend_ok_next  = 1'b0;
                        run_code_next = rsrd_pkg::ST_TO_FLUSH;
                        state_next    = S_FLUSH;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_FLUSH:
            begin
                if (cur_valid && cmp_eq)
                begin
                    // Next in the run: release any held result, hold this one, restart scan
                    if (pend_ok_reg)
                    begin
                        strobe_next = 1'b1;
                        status_next = run_code_reg;
                        dlv_next    = 1'b1;
                        oseq_next   = pend_seq_reg;
                        otag_next   = pend_tag_reg;
                    end
                    valid_next[idx_reg] = 1'b0;
                    pend_ok_next        = 1'b1;
                    pend_seq_next       = cur_seq;
                    pend_tag_next       = cur_tag;
                    exp_next            = exp_reg + SEQ_W'(1);
                    idx_next            = '0;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    // Run ends: the held result is the final one
                    strobe_next = 1'b1;
                    status_next = run_code_reg;
                    dlv_next    = 1'b1;
                    oseq_next   = pend_seq_reg;
                    otag_next   = pend_tag_reg;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= 1'b0;
            ck_reg       <= 1'b0;
            txs_reg      <= 1'b0;
            sq_reg       <= '0;
            tag_reg      <= '0;
            exp_reg      <= '0;
            limit_reg    <= rsrd_pkg::LIMIT_RESET;
            valid_reg    <= '0;
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            occ_reg      <= '0;
            free_ok_reg  <= 1'b0;
            free_idx_reg <= '0;
            best_ok_reg  <= 1'b0;
            best_reg     <= '0;
            pend_ok_reg  <= 1'b0;
            run_code_reg <= rsrd_pkg::ST_DELIVER;
            pend_seq_reg <= '0;
            pend_tag_reg <= '0;
            strobe_reg   <= 1'b0;
            status_reg   <= rsrd_pkg::ST_DELIVER;
            dlv_reg      <= 1'b0;
            oseq_reg     <= '0;
            otag_reg     <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            ck_reg       <= ck_next;
            txs_reg      <= txs_next;
            sq_reg       <= sq_next;
            tag_reg      <= tag_next;
            exp_reg      <= exp_next;
            limit_reg    <= limit_next;
            valid_reg    <= valid_next;
            idx_reg      <= idx_next;
            hit_reg      <= hit_next;
            occ_reg      <= occ_next;
            free_ok_reg  <= free_ok_next;
            free_idx_reg <= free_idx_next;
            best_ok_reg  <= best_ok_next;
            best_reg     <= best_next;
            pend_ok_reg  <= pend_ok_next;
            run_code_reg <= run_code_next;
            pend_seq_reg <= pend_seq_next;
            pend_tag_reg <= pend_tag_next;
            strobe_reg   <= strobe_next;
            status_reg   <= status_next;
            dlv_reg      <= dlv_next;
            oseq_reg     <= oseq_next;
            otag_reg     <= otag_next;
            last_reg     <= last_next;
        end
    end

    // Slot payload: only read behind a valid bit, so no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_seq_reg[wr_idx] <= sq_reg;
            slot_tag_reg[wr_idx] <= tag_reg;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    // Accept a limit transfer only while no command is in flight or arriving
    assign cfg_ready    = !busy && !start;
    assign result_valid = strobe_reg;
    assign status       = status_reg;
    assign delivered    = dlv_reg;
    assign out_seq      = oseq_reg;
    assign out_tag      = otag_reg;
    assign last         = last_reg;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH   = rsrd_pkg::DEFER_DEPTH_DEF;
    localparam int TAG_W   = rsrd_pkg::TAG_WIDTH_DEF;
    localparam int SEQ_W   = rsrd_pkg::SEQ_W;
    localparam int LIMIT_W = rsrd_pkg::LIMIT_W;
    localparam int STAT_W  = rsrd_pkg::STAT_W;

    // One result as the block reports it
    typedef struct packed {
        rsrd_pkg::status_t  st;
        logic               dlv;
        logic [SEQ_W-1:0]   sq;
        logic [TAG_W-1:0]   tg;
        logic               lst;
    } outcome_t;

    typedef enum logic {
        ROW_CMD = 1'b0,
        ROW_CFG = 1'b1
    } row_kind_t;

    // One line of the directed table: either a command or a defer-limit write.
    // Rows marked fixed carry their single result by hand.
    typedef struct packed {
        row_kind_t          kind;
        logic [LIMIT_W-1:0] lim;
        logic               op;
        logic               ck;
        logic               txs;
        logic [SEQ_W-1:0]   sq;
        logic [TAG_W-1:0]   tg;
        logic               fixed;
        rsrd_pkg::status_t  st;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                opcode;
    logic                checksum_ok;
    logic [SEQ_W-1:0]    seq_number;
    logic [TAG_W-1:0]    payload_tag;
    logic                tx_started;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  cfg_data;
    logic                result_valid;
    logic [STAT_W-1:0]   status;
    logic                delivered;
    logic [SEQ_W-1:0]    out_seq;
    logic [TAG_W-1:0]    out_tag;
    logic                last;

    // Shadow copy of the reorder state
    logic [SEQ_W-1:0]    next_seq;
    logic                held_vld [DEPTH];
    logic [SEQ_W-1:0]    held_seq [DEPTH];
    logic [TAG_W-1:0]    held_tag [DEPTH];
    logic [LIMIT_W-1:0]  defer_lim;

    outcome_t            step_outcomes [$];   // results of the command just accepted
    outcome_t            owed_results [$];    // results the block still has to report
    outcome_t            head;
    dir_row_t            dir_tab [$];

    int                  n_errors;
    int                  n_cmds;
    int                  n_directed;
    int                  n_results;
    int                  n_deliv;
    int                  n_cfg;

    redundant_seq_reorder_dedup_unit #(
        .DEFER_DEPTH (DEPTH),
        .TAG_WIDTH   (TAG_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .checksum_ok  (checksum_ok),
        .seq_number   (seq_number),
        .payload_tag  (payload_tag),
        .tx_started   (tx_started),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .status       (status),
        .delivered    (delivered),
        .out_seq      (out_seq),
        .out_tag      (out_tag),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // Shadow reorder logic
    // ---------------------------------------------------------------

    function automatic void add_outcome(input rsrd_pkg::status_t st, input logic dlv,
                                        input logic [SEQ_W-1:0] sq,
                                        input logic [TAG_W-1:0] tg);
        outcome_t o;
        o.st  = st;
        o.dlv = dlv;
        o.sq  = sq;
        o.tg  = tg;
        o.lst = 1'b0;
        step_outcomes.push_back(o);
    endfunction

    function automatic int find_held(input logic [SEQ_W-1:0] sq);
        int hit;
        hit = -1;
        for (int i = 0; i < DEPTH; i++)
            if (hit < 0 && held_vld[i] && held_seq[i] == sq)
                hit = i;
        return hit;
    endfunction

    // Deliver the deferred run that continues from the expected number
    function automatic void release_run(input rsrd_pkg::status_t st);
        int s;
        s = find_held(next_seq);
        while (s >= 0)
        begin
            add_outcome(st, 1'b1, held_seq[s], held_tag[s]);
            held_vld[s] = 1'b0;
            next_seq = next_seq + SEQ_W'(1);
            s = find_held(next_seq);
        end
    endfunction

    function automatic void reorder_step(input logic op, input logic ck,
                                         input logic [SEQ_W-1:0] sq,
                                         input logic [TAG_W-1:0] tg,
                                         input logic txs);
        int        low;
        int        occ;
        int        cap;
        int        free;
        logic [39:0] win_top;
        outcome_t  o;
        step_outcomes.delete();
        win_top = 40'(next_seq);
        win_top = win_top + 40'(int'(defer_lim) * rsrd_pkg::WINDOW_FACTOR);
        if (op == rsrd_pkg::OP_TIMEOUT)
        begin
            low = -1;
            for (int i = 0; i < DEPTH; i++)
                if (held_vld[i] && (low < 0 || held_seq[i] < held_seq[low]))
                    low = i;
            if (low < 0)
                add_outcome(rsrd_pkg::ST_TO_EMPTY, 1'b0, '0, '0);
            else
            begin
                next_seq = held_seq[low];
                release_run(rsrd_pkg::ST_TO_FLUSH);
            end
        end
        else if (!ck)
            add_outcome(rsrd_pkg::ST_BAD_CK, 1'b0, '0, '0);
        else if (next_seq == '0 && !txs && sq != '0)
            add_outcome(rsrd_pkg::ST_FIRST_NZ, 1'b0, '0, '0);
        else if (sq < next_seq)
            add_outcome(rsrd_pkg::ST_OLD_DUP, 1'b0, '0, '0);
        else if (sq == next_seq)
        begin
            add_outcome(rsrd_pkg::ST_DELIVER, 1'b1, sq, tg);
            next_seq = next_seq + SEQ_W'(1);
            release_run(rsrd_pkg::ST_DELIVER);
        end
        else if ({8'd0, sq} <= win_top)
        begin
            occ = 0;
            free = -1;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (held_vld[i])
                    occ++;
                else if (free < 0)
                    free = i;
            end
            cap = int'(defer_lim);
            if (cap > DEPTH)
                cap = DEPTH;
            if (cap > rsrd_pkg::STORE_MAX)
                cap = rsrd_pkg::STORE_MAX;
            if (find_held(sq) >= 0)
                add_outcome(rsrd_pkg::ST_DEFER_DUP, 1'b0, '0, '0);
            else if (occ >= cap)
                add_outcome(rsrd_pkg::ST_FULL, 1'b0, '0, '0);
            else
            begin
                held_vld[free] = 1'b1;
                held_seq[free] = sq;
                held_tag[free] = tg;
                add_outcome(rsrd_pkg::ST_DEFERRED, 1'b0, '0, '0);
            end
        end
        else
            add_outcome(rsrd_pkg::ST_TOO_FAR, 1'b0, '0, '0);
        o = step_outcomes.pop_back();
        o.lst = 1'b1;
        step_outcomes.push_back(o);
    endfunction

    // ---------------------------------------------------------------
    // Directed table rows
    // ---------------------------------------------------------------

    function automatic dir_row_t pkt_row(input logic ck, input logic txs,
                                         input logic [SEQ_W-1:0] sq,
                                         input logic [TAG_W-1:0] tg,
                                         input logic fixed, input rsrd_pkg::status_t st);
        dir_row_t r;
        r = '0;
        r.kind  = ROW_CMD;
        r.op    = rsrd_pkg::OP_PACKET;
        r.ck    = ck;
        r.txs   = txs;
        r.sq    = sq;
        r.tg    = tg;
        r.fixed = fixed;
        r.st    = st;
        return r;
    endfunction

    // Timeout rows carry junk packet fields: the op must ignore them
    function automatic dir_row_t tmo_row(input logic fixed, input rsrd_pkg::status_t st);
        dir_row_t r;
        r = '0;
        r.kind  = ROW_CMD;
        r.op    = rsrd_pkg::OP_TIMEOUT;
        r.sq    = '1;
        r.tg    = '1;
        r.fixed = fixed;
        r.st    = st;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [LIMIT_W-1:0] v);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.lim  = v;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------

    // Present one command, hold it until the transfer, then record what the
    // block owes for it: either the given result or the shadow prediction.
    task automatic send_cmd(input logic op, input logic ck,
                            input logic [SEQ_W-1:0] sq, input logic [TAG_W-1:0] tg,
                            input logic txs, input logic use_given,
                            input outcome_t given);
        opcode      <= op;
        checksum_ok <= ck;
        seq_number  <= sq;
        payload_tag <= tg;
        tx_started  <= txs;
        if (!start)
            start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        reorder_step(op, ck, sq, tg, txs);
        n_cmds++;
        if (use_given)
            owed_results.push_back(given);
        else
            foreach (step_outcomes[i])
                owed_results.push_back(step_outcomes[i]);
    endtask

    // Drop start for a random gap: mostly none, some short, a few long
    task automatic idle_sender(input logic no_idle);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (!no_idle && r >= 65)
            gap = (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off until every owed result has come and the block is idle
    task automatic drain_block();
        start <= 1'b0;
        while (owed_results.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        defer_lim = v;
        n_cfg++;
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result checking: results cannot be stalled, so take one on every
    // edge that ends a strobe cycle and compare it with the oldest owed one.
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            n_results++;
            if (delivered)
                n_deliv++;
            if (owed_results.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result st=%0d dl=%0b sq=%0h tg=%0h ls=%0b",
                         $time, status, delivered, out_seq, out_tag, last);
            end
            else
            begin
                head = owed_results.pop_front();
                if (status !== head.st || delivered !== head.dlv || out_seq !== head.sq
                    || out_tag !== head.tg || last !== head.lst)
                begin
                    n_errors++;
                    $display("%0t: expected st=%0d dl=%0b sq=%0h tg=%0h ls=%0b,",
                             $time, head.st, head.dlv, head.sq, head.tg, head.lst);
                    $display("    got st=%0d dl=%0b sq=%0h tg=%0h ls=%0b",
                             status, delivered, out_seq, out_tag, last);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial
    begin
        dir_row_t            row;
        outcome_t            given;
        logic [LIMIT_W-1:0]  phase_lim [8];
        logic [SEQ_W-1:0]    shuf [10];
        logic [SEQ_W-1:0]    tmp;
        logic [SEQ_W-1:0]    sq_r;
        logic [TAG_W-1:0]    tg_r;
        logic                op_r;
        logic                ck_r;
        logic                txs_r;
        logic                no_idle;
        logic [SEQ_W-1:0]    burst_q [$];
        int                  nb;
        int                  k;
        int                  r;

        // Drive every input to a known value and hold reset
        rst_n       = 1'b0;
        start       <= 1'b0;
        opcode      <= rsrd_pkg::OP_PACKET;
        checksum_ok <= 1'b0;
        seq_number  <= '0;
        payload_tag <= '0;
        tx_started  <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;

        next_seq  = '0;
        defer_lim = rsrd_pkg::LIMIT_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            held_vld[i] = 1'b0;
            held_seq[i] = '0;
            held_tag[i] = '0;
        end
        n_errors   = 0;
        n_cmds     = 0;
        n_results  = 0;
        n_deliv    = 0;
        n_cfg      = 0;

        // Directed walk, starting from reset with a defer limit of 8
        dir_tab.push_back(pkt_row(1'b0, 1'b1, 32'd5, 16'h1111, 1'b1, rsrd_pkg::ST_BAD_CK));
        dir_tab.push_back(pkt_row(1'b1, 1'b0, 32'd7, 16'h2222, 1'b1, rsrd_pkg::ST_FIRST_NZ));
        dir_tab.push_back(pkt_row(1'b1, 1'b0, 32'd0, 16'h0000, 1'b1, rsrd_pkg::ST_DELIVER));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd3, 16'h3333, 1'b1, rsrd_pkg::ST_DEFERRED));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd3, 16'h4444, 1'b1, rsrd_pkg::ST_DEFER_DUP));
        dir_tab.push_back(tmo_row(1'b0, rsrd_pkg::ST_TO_FLUSH));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd0, 16'h5555, 1'b1, rsrd_pkg::ST_OLD_DUP));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd4, 16'hFFFF, 1'b1, rsrd_pkg::ST_DELIVER));
        // Window edge: expected 5, limit 8 -> last accepted number is 85
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd85, 16'h0085, 1'b1, rsrd_pkg::ST_DEFERRED));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd86, 16'h0086, 1'b1, rsrd_pkg::ST_TOO_FAR));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'hFFFF_FFFF, 16'hAAAA, 1'b1,
                                  rsrd_pkg::ST_TOO_FAR));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd7, 16'h0007, 1'b1, rsrd_pkg::ST_DEFERRED));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd6, 16'h0006, 1'b1, rsrd_pkg::ST_DEFERRED));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd5, 16'h0005, 1'b0, rsrd_pkg::ST_DELIVER));
        dir_tab.push_back(tmo_row(1'b0, rsrd_pkg::ST_TO_FLUSH));
        dir_tab.push_back(tmo_row(1'b1, rsrd_pkg::ST_TO_EMPTY));
        // Smallest store
        dir_tab.push_back(cfg_row(4'd1));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd88, 16'h0088, 1'b1, rsrd_pkg::ST_DEFERRED));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd89, 16'h0089, 1'b1, rsrd_pkg::ST_FULL));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd86, 16'hBEEF, 1'b0, rsrd_pkg::ST_DELIVER));
        // No window at all: anything ahead is too far, in-order still flows
        dir_tab.push_back(cfg_row(4'd0));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd90, 16'h0090, 1'b1, rsrd_pkg::ST_TOO_FAR));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd87, 16'h0087, 1'b0, rsrd_pkg::ST_DELIVER));
        // Largest register value, then lower it below the occupancy
        dir_tab.push_back(cfg_row(4'd15));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd92, 16'h0092, 1'b1, rsrd_pkg::ST_DEFERRED));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd93, 16'h0093, 1'b1, rsrd_pkg::ST_DEFERRED));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd94, 16'h0094, 1'b1, rsrd_pkg::ST_DEFERRED));
        dir_tab.push_back(cfg_row(4'd2));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd95, 16'h0095, 1'b1, rsrd_pkg::ST_FULL));
        dir_tab.push_back(pkt_row(1'b1, 1'b1, 32'd93, 16'h1093, 1'b1, rsrd_pkg::ST_DEFER_DUP));
        dir_tab.push_back(tmo_row(1'b0, rsrd_pkg::ST_TO_FLUSH));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            row = dir_tab[i];
            if (row.kind == ROW_CFG)
            begin
                drain_block();
                write_limit(row.lim);
            end
            else
            begin
                given.st  = row.st;
                given.dlv = (row.st == rsrd_pkg::ST_DELIVER);
                given.sq  = given.dlv ? row.sq : '0;
                given.tg  = given.dlv ? row.tg : '0;
                given.lst = 1'b1;
                send_cmd(row.op, row.ck, row.sq, row.tg, row.txs, row.fixed, given);
                idle_sender(1'b0);
            end
        end
        n_directed = n_cmds;

        // Random phases; the store carries over, so a lower limit often
        // lands below the current occupancy
        phase_lim[0] = 4'd1;
        phase_lim[1] = 4'd15;
        phase_lim[2] = 4'd0;
        phase_lim[3] = 4'd3;
        phase_lim[4] = 4'd8;
        phase_lim[5] = 4'd5;
        phase_lim[6] = 4'd2;
        phase_lim[7] = LIMIT_W'($urandom_range(0, 15));

        for (int ph = 0; ph < 8; ph++)
        begin
            drain_block();
            write_limit(phase_lim[ph]);
            no_idle = (ph == 2 || ph == 5);
            for (int n = 0; n < 17; n++)
            begin
                // Start a shuffled burst: each number from the expected one
                // onward arrives twice, as over two redundant channels
                if (burst_q.size() == 0 && $urandom_range(0, 2) == 0)
                begin
                    nb = $urandom_range(2, 5);
                    for (int j = 0; j < 2 * nb; j++)
                        shuf[j] = next_seq + SEQ_W'(j / 2);
                    for (int j = 2 * nb - 1; j > 0; j--)
                    begin
                        k = $urandom_range(0, j);
                        tmp = shuf[j];
                        shuf[j] = shuf[k];
                        shuf[k] = tmp;
                    end
                    for (int j = 0; j < 2 * nb; j++)
                        burst_q.push_back(shuf[j]);
                end

                op_r  = rsrd_pkg::OP_PACKET;
                ck_r  = 1'b1;
                txs_r = ($urandom_range(0, 9) != 0);
                tg_r  = TAG_W'($urandom_range(0, 65535));
                if (burst_q.size() != 0)
                begin
                    sq_r  = burst_q.pop_front();
                    txs_r = 1'b1;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 8)
                    begin
                        op_r = rsrd_pkg::OP_TIMEOUT;
                        ck_r = 1'($urandom_range(0, 1));
                        sq_r = $urandom();
                    end
                    else if (r < 16)
                    begin
                        ck_r = 1'b0;
                        sq_r = $urandom();
                    end
                    else if (r < 24)
                        sq_r = $urandom();
                    else if (r < 34)
                        sq_r = next_seq - SEQ_W'($urandom_range(1, 20));
                    else if (r < 50)
                        sq_r = next_seq;
                    else if (r < 62)
                    begin
                        // Repeat a number already waiting in the store
                        k = -1;
                        for (int j = 0; j < DEPTH; j++)
                            if (held_vld[j] && (k < 0 || $urandom_range(0, 1) == 1))
                                k = j;
                        sq_r = (k >= 0) ? held_seq[k] : next_seq + SEQ_W'(1);
                    end
                    else
                        sq_r = next_seq + SEQ_W'($urandom_range(1,
                                   int'(defer_lim) * rsrd_pkg::WINDOW_FACTOR + 5));
                end

                send_cmd(op_r, ck_r, sq_r, tg_r, txs_r, 1'b0, '0);
                idle_sender(no_idle);
                if ($urandom_range(0, 29) == 0)
                    drain_block();
            end
        end

        // Wait out every owed result, then leave room for strays
        drain_block();
        repeat (100) @(posedge clk);

        $display("Ran %0d commands (%0d from the directed table) over %0d defer-limit writes.",
                 n_cmds, n_directed, n_cfg);
        $display("Checked %0d results, %0d of them deliveries; %0d mismatches.",
                 n_results, n_deliv, n_errors);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- redundant_seq_reorder_dedup_unit.f -----
rtl/rsrd_pkg.sv
rtl/redundant_seq_reorder_dedup_unit.sv
verif/tb.sv
